### hdl/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
`timescale 1ns / 1ps
package mpct_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SENSITIVITY = 2'd0;
  localparam logic [1:0] REG_START_X     = 2'd1;
  localparam logic [1:0] REG_START_Y     = 2'd2;

  // Item kinds carried on s_tuser
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Field widths
  localparam int unsigned POS_X_W = 10;
  localparam int unsigned POS_Y_W = 9;
  localparam int unsigned SENS_W  = 7;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned DIV_STEPS = 8;

  // Largest values the position fields can hold
  localparam int unsigned POS_X_MAX = 1023;
  localparam int unsigned POS_Y_MAX = 511;

  // Controller to datapath commands
  typedef struct packed {
    logic byte_en;    // take s_tdata as a packet byte
    logic div_start;  // load divider with delta magnitudes
    logic div_step;   // one restoring division step on both axes
    logic commit;     // update position and load output register
  } mpct_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register empty or being drained
  } mpct_sts_t;

endpackage

### hdl/mpct_ctrl.sv
// Controller state machine for the mouse packet cursor tracker.
`timescale 1ns / 1ps
module mpct_ctrl import mpct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      s_tuser,     // [0] kind
  input  mpct_sts_t sts,
  output mpct_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [2:0] step, step_next;
  logic accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == KIND_TICK) begin
            cmd.div_start = 1'b1;
            step_next     = '0;
            state_next    = ST_DIV;
          end else begin
            cmd.byte_en = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 3'd1;
        if (step == 3'(DIV_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

### hdl/mpct_dp.sv
// Datapath: packet bytes, delta dividers, cursor position and output register.
`timescale 1ns / 1ps
module mpct_dp import mpct_pkg::*; #(
  parameter int unsigned SCREEN_W = 640,
  parameter int unsigned SCREEN_H = 480
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       s_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,
  input  mpct_cmd_t        cmd,
  output mpct_sts_t        sts
);

  localparam int unsigned HX = (SCREEN_W < POS_X_MAX) ? SCREEN_W : POS_X_MAX;
  localparam int unsigned HY = (SCREEN_H < POS_Y_MAX) ? SCREEN_H : POS_Y_MAX;

  logic [1:0]         byte_phase;
  logic [7:0]         held_x_byte;
  logic [7:0]         delta_x;
  logic [7:0]         delta_y;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_Y_W-1:0] pos_y;
  logic [SENS_W-1:0]  sensitivity;
  logic [POS_X_W-1:0] out_x;
  logic [POS_Y_W-1:0] out_y;

  // Divider state per axis: quotient shift register and remainder
  logic [7:0]        quo_x, quo_y;
  logic [SENS_W-1:0] rem_x, rem_y;
  logic              neg_x, neg_y;

  logic [SENS_W-1:0] divisor;
  logic [7:0]        trial_x, trial_y;
  logic              ge_x, ge_y;
  logic [7:0]        diff_x, diff_y;
  logic signed [8:0] sq_x, sq_y;
  logic signed [11:0] nx, ny;
  logic [POS_X_W-1:0] cx;
  logic [POS_Y_W-1:0] cy;
  logic               cfg_we;

  assign cfg_we  = cfg_valid && cfg_ready;
  assign divisor = (sensitivity == '0) ? SENS_W'(1) : sensitivity;

  // One restoring step on each axis
  assign trial_x = {rem_x, quo_x[7]};
  assign trial_y = {rem_y, quo_y[7]};
  assign ge_x    = trial_x >= {1'b0, divisor};
  assign ge_y    = trial_y >= {1'b0, divisor};
  assign diff_x  = trial_x - {1'b0, divisor};
  assign diff_y  = trial_y - {1'b0, divisor};

  // Signed quotients, truncated toward zero
  assign sq_x = neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
  assign sq_y = neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});

  // New position and clamp
  assign nx = $signed({2'b00, pos_x}) + 12'(sq_x);
  assign ny = $signed({3'b000, pos_y}) - 12'(sq_y);

  always_comb begin
    if (nx < 0)                       cx = '0;
    else if (nx > $signed(12'(HX)))   cx = POS_X_W'(HX);
    else                              cx = nx[POS_X_W-1:0];
    if (ny < 0)                       cy = '0;
    else if (ny > $signed(12'(HY)))   cy = POS_Y_W'(HY);
    else                              cy = ny[POS_Y_W-1:0];
  end

  // Packet assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase  <= '0;
      held_x_byte <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
    end else if (cmd.byte_en) begin
      unique case (byte_phase)
        2'd0: byte_phase <= 2'd1;
        2'd1: begin
          held_x_byte <= s_tdata;
          byte_phase  <= 2'd2;
        end
        default: begin
          delta_x    <= held_x_byte;
          delta_y    <= s_tdata;
          byte_phase <= 2'd0;
        end
      endcase
    end
  end

  // Iterative dividers, both axes in lockstep
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_x <= delta_x[7] ? 8'(-delta_x) : delta_x;
      quo_y <= delta_y[7] ? 8'(-delta_y) : delta_y;
      neg_x <= delta_x[7];
      neg_y <= delta_y[7];
      rem_x <= '0;
      rem_y <= '0;
    end else if (cmd.div_step) begin
      quo_x <= {quo_x[6:0], ge_x};
      quo_y <= {quo_y[6:0], ge_y};
      rem_x <= ge_x ? diff_x[SENS_W-1:0] : trial_x[SENS_W-1:0];
      rem_y <= ge_y ? diff_y[SENS_W-1:0] : trial_y[SENS_W-1:0];
    end
  end

  // Configuration and cursor position
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= SENS_W'(1);
      pos_x       <= '0;
      pos_y       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSITIVITY: sensitivity <= cfg_data[SENS_W-1:0];
        REG_START_X:     pos_x       <= cfg_data[POS_X_W-1:0];
        REG_START_Y:     pos_y       <= cfg_data[POS_Y_W-1:0];
        default: ;
      endcase
    end else if (cmd.commit) begin
      pos_x <= cx;
      pos_y <= cy;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_x <= cx;
      out_y <= cy;
    end
  end

  assign m_tdata      = {5'b00000, out_y, out_x};
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

### hdl/mouse_packet_cursor_tracker.sv
// Top level of the mouse packet cursor tracker.
// Byte items produce no result.
// A tick item is accepted, then a shared-step restoring divider runs
// (one quotient bit per cycle on both axes) and the tick is committed once the output register is free;
// the result sits in an output register, and no new item is taken until the tick has been committed.
// Synchronous active-high reset: sensitivity 1, cursor at 0,0, deltas zero.
`timescale 1ns / 1ps
module mouse_packet_cursor_tracker import mpct_pkg::*; #(
  parameter int unsigned SCREEN_W = 640,
  parameter int unsigned SCREEN_H = 480
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,    // [7:0] rx_byte
  input  logic             s_tuser,    // [0] kind
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,    // [9:0] cursor_x, [18:10] cursor_y, rest zero
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  mpct_cmd_t cmd;
  mpct_sts_t sts;

  assign cfg_ready = 1'b1;

  mpct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpct_dp #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### hdl/mpct_chk.sv
// Port-level checker for the mouse packet cursor tracker, bound to the top level.
`timescale 1ns / 1ps
module mpct_chk #(
  parameter int unsigned SCREEN_W = 640,
  parameter int unsigned SCREEN_H = 480
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  localparam int unsigned HX = (SCREEN_W < 1023) ? SCREEN_W : 1023;
  localparam int unsigned HY = (SCREEN_H < 511) ? SCREEN_H : 511;

  // No result is pending right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Results stay within the clamp bounds
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:0] <= 10'(HX))
    else $error("cursor_x beyond bound");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:10] <= 9'(HY))
    else $error("cursor_y beyond bound");

  // A byte item never raises a result on the next cycle
  a_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
    else $error("result after byte item");

endmodule

bind mouse_packet_cursor_tracker mpct_chk #(
  .SCREEN_W (SCREEN_W),
  .SCREEN_H (SCREEN_H)
) u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### verif/mouse_packet_cursor_tracker_tb.sv
// Self-checking testbench for the mouse packet cursor tracker.
`timescale 1ns / 1ps
module mouse_packet_cursor_tracker_tb;
  import mpct_pkg::*;

  localparam int unsigned SCREEN_W = 640;
  localparam int unsigned SCREEN_H = 480;
  localparam int X_HI = (SCREEN_W < POS_X_MAX) ? SCREEN_W : POS_X_MAX;
  localparam int Y_HI = (SCREEN_H < POS_Y_MAX) ? SCREEN_H : POS_Y_MAX;
  // index with no register behind it
  localparam logic [1:0] REG_NONE = 2'd3;
  // cycles a tick may still be in flight when the queue runs dry
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam int IDLE_PCT = 19;

  typedef struct packed {
    logic [4:0]         pad;
    logic [POS_Y_W-1:0] y;
    logic [POS_X_W-1:0] x;
  } cursor_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tuser = KIND_BYTE;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [23:0]      m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_SENSITIVITY;
  logic [CFG_W-1:0] cfg_data = '0;

  mouse_packet_cursor_tracker #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tracker state mirrored in the testbench
  logic [1:0]         trk_phase = '0;
  logic [7:0]         trk_held = '0;
  logic [7:0]         trk_dx = '0;
  logic [7:0]         trk_dy = '0;
  logic [POS_X_W-1:0] trk_px = '0;
  logic [POS_Y_W-1:0] trk_py = '0;
  logic [SENS_W-1:0]  trk_sens = 7'd1;

  cursor_word_t pending_cursor_q[$];
  int mismatches = 0;
  int sent_items = 0;

  // Idle controls and long receiver hold requests
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_requests = 0;
  int hold_len = 0;

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the mirrored tracker by one accepted item
  function automatic void track_cursor(logic kind, logic [7:0] rx_byte);
    int div;
    int nx;
    int ny;
    cursor_word_t w;
    if (kind == KIND_BYTE) begin
      if (trk_phase == 2'd0) begin
        trk_phase = 2'd1;
      end else if (trk_phase == 2'd1) begin
        trk_held = rx_byte;
        trk_phase = 2'd2;
      end else begin
        trk_dx = trk_held;
        trk_dy = rx_byte;
        trk_phase = 2'd0;
      end
      return;
    end
    // zero sensitivity means no scaling
    div = (trk_sens == 0) ? 1 : int'(trk_sens);
    nx = int'(trk_px) + int'($signed(trk_dx)) / div;
    ny = int'(trk_py) - int'($signed(trk_dy)) / div;
    trk_px = POS_X_W'(clamp_coord(nx, X_HI));
    trk_py = POS_Y_W'(clamp_coord(ny, Y_HI));
    w = '0;
    w.x = trk_px;
    w.y = trk_py;
    pending_cursor_q.push_back(w);
  endfunction

  // Offer one item, with random gaps, and wait for it to be taken
  task automatic send_item(input logic kind, input logic [7:0] rx_byte);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= rx_byte;
    do @(posedge clk); while (!s_tready);
    track_cursor(kind, rx_byte);
    sent_items++;
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] bx, input logic [7:0] by);
    send_item(KIND_BYTE, hdr);
    send_item(KIND_BYTE, bx);
    send_item(KIND_BYTE, by);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(255)));
  endtask

  // Stop sending, wait for every expected cursor, then let the block go idle
  task automatic settle();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (pending_cursor_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_cursor_q.size() != 0) begin
      $error("%0d expected cursor items never arrived", pending_cursor_q.size());
      mismatches++;
      pending_cursor_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SENSITIVITY: trk_sens = value[SENS_W-1:0];
      REG_START_X: trk_px = value[POS_X_W-1:0];
      REG_START_Y: trk_py = value[POS_Y_W-1:0];
      default: ;
    endcase
    // cfg_valid stays low before the next write
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg_value(input logic [1:0] idx);
    case ($urandom_range(4))
      0: return '0;
      1: return (idx == REG_SENSITIVITY) ? CFG_W'(127) :
                (idx == REG_START_X) ? CFG_W'(SCREEN_W) : CFG_W'(SCREEN_H);
      2: return '1;
      3: return (idx == REG_SENSITIVITY) ? CFG_W'($urandom_range(1, 8)) :
                CFG_W'($urandom_range(0, 1023));
      default: return CFG_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Receiver: random stalls, plus long holds on request
  int hold_left = 0;
  int holds_done = 0;
  always @(posedge clk) begin
    if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each delivered cursor item with the oldest expectation
  always @(posedge clk) begin
    cursor_word_t got;
    cursor_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_cursor_q.size() == 0) begin
        $error("unexpected cursor item x=%0d y=%0d", got.x, got.y);
        mismatches++;
      end else begin
        want = pending_cursor_q.pop_front();
        if (got.x !== want.x) begin
          $error("cursor_x: expected %0d, actual %0d", want.x, got.x);
          mismatches++;
        end
        if (got.y !== want.y) begin
          $error("cursor_y: expected %0d, actual %0d", want.y, got.y);
          mismatches++;
        end
      end
    end
  end

  // Deltas at their extremes, repeated ticks, clamping at the far edges
  task automatic test_deltas();
    send_item(KIND_TICK, 8'hFF);
    send_packet(8'h00, 8'h7F, 8'h80);
    send_ticks(6);
    send_packet(8'hFF, 8'h80, 8'h7F);
    send_item(KIND_TICK, 8'h00);
    send_packet(8'h08, 8'hFF, 8'h01);
    send_item(KIND_TICK, 8'h55);
  endtask

  // Zero, largest and odd divisors, truncation of negative quotients
  task automatic test_sensitivity();
    settle();
    write_reg(REG_SENSITIVITY, '0);
    write_reg(REG_NONE, '1);
    send_packet(8'hAA, 8'h80, 8'h7F);
    send_ticks(6);
    settle();
    write_reg(REG_SENSITIVITY, '1);
    send_item(KIND_TICK, 8'h00);
    settle();
    write_reg(REG_SENSITIVITY, CFG_W'(3));
    send_packet(8'h00, 8'hF9, 8'h07);
    send_ticks(2);
  endtask

  // Start positions outside the screen are clamped by the next tick
  task automatic test_start_points();
    settle();
    write_reg(REG_START_X, '1);
    write_reg(REG_START_Y, '1);
    send_packet(8'h00, 8'h00, 8'h00);
    send_item(KIND_TICK, 8'h00);
    settle();
    write_reg(REG_START_X, CFG_W'(SCREEN_W));
    write_reg(REG_START_Y, CFG_W'(SCREEN_H));
    send_item(KIND_TICK, 8'h00);
    settle();
    write_reg(REG_START_X, '0);
    write_reg(REG_START_Y, '0);
    write_reg(REG_SENSITIVITY, CFG_W'(1));
  endtask

  // Receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    send_packet(8'h00, 8'h05, 8'hFB);
    hold_len = 300;
    hold_requests++;
    tx_idle_en = 1'b0;
    send_ticks(40);
    tx_idle_en = 1'b1;
  endtask

  // Mostly whole packets followed by ticks, with stray bytes and lone ticks;
  // registers change between phases
  task automatic test_random();
    int phase_num;
    int r;
    phase_num = 0;
    while (sent_items < 1000) begin
      settle();
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(1) == 1)
          write_reg(2'(k), pick_reg_value(2'(k)));
      end
      // one stretch runs with no idling on either side
      tx_idle_en = (phase_num != 1);
      rx_idle_en = (phase_num != 1);
      repeat (90) begin
        r = $urandom_range(99);
        if (r < 70) begin
          send_packet(8'($urandom_range(255)), pick_byte(), pick_byte());
          send_ticks($urandom_range(1, 3));
        end else if (r < 85) begin
          send_item(KIND_TICK, 8'($urandom_range(255)));
        end else begin
          send_item(KIND_BYTE, pick_byte());
        end
      end
      phase_num++;
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_deltas();
    test_sensitivity();
    test_start_points();
    test_backpressure();
    test_random();
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
